/* rtl/core/tlvchp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV container header parser: shared package
// Widths, register indexes, status codes and the structures passed between
// the configuration block, the parser and the result register.
// ----------------------------------------------------------------------------
package tlvchp_pkg;

    // Offsets and lengths are reported in this many bits.
    localparam int OFFSET_BITS = 24;
    localparam int POS_BITS    = OFFSET_BITS + 1;

    localparam int HEADER_BYTES = 20;
    localparam int MAGIC_BYTES  = 8;
    localparam int WORD_BYTES   = 4;

    // Configuration port
    localparam int CFG_ADDR_BITS = 6;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [2:0] REG_MAGIC         = 3'd0;
    localparam logic [2:0] REG_VERSION       = 3'd1;
    localparam logic [2:0] REG_IR_TYPE       = 3'd2;
    localparam logic [2:0] REG_WEIGHTS_TYPE  = 3'd3;
    localparam logic [2:0] REG_METADATA_TYPE = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT       = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_TRUNC_HDR   = 3'd4;
    localparam logic [2:0] ST_TRUNC_BODY  = 3'd5;
    localparam logic [2:0] ST_NO_IR       = 3'd6;
    localparam logic [2:0] ST_TOO_LONG    = 3'd7;

    typedef struct packed {
        logic [63:0] magic_value;
        logic [31:0] expected_version;
        logic [31:0] ir_type_code;
        logic [31:0] weights_type_code;
        logic [31:0] metadata_type_code;
    } cfg_t;

    // Declared from the top bit down, so status sits in the lowest bits.
    typedef struct packed {
        logic [OFFSET_BITS-1:0] metadata_length;
        logic [OFFSET_BITS-1:0] metadata_offset;
        logic [OFFSET_BITS-1:0] weights_length;
        logic [OFFSET_BITS-1:0] weights_offset;
        logic [OFFSET_BITS-1:0] ir_length;
        logic [OFFSET_BITS-1:0] ir_offset;
        logic [31:0]            flags_word;
        logic [31:0]            version_word;
        logic [2:0]             status;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

endpackage

/* rtl/core/tlvchp_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV container header parser: configuration registers
// APB-style register file holding the magic value, the accepted version and
// the three section type codes.
// ----------------------------------------------------------------------------
module tlvchp_cfg_regs
    import tlvchp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_value        <= 64'd0;
            cfg_reg.expected_version   <= 32'd1;
            cfg_reg.ir_type_code       <= 32'd1;
            cfg_reg.weights_type_code  <= 32'd2;
            cfg_reg.metadata_type_code <= 32'd3;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_MAGIC:         cfg_reg.magic_value        <= pwdata;
                REG_VERSION:       cfg_reg.expected_version   <= pwdata[31:0];
                REG_IR_TYPE:       cfg_reg.ir_type_code       <= pwdata[31:0];
                REG_WEIGHTS_TYPE:  cfg_reg.weights_type_code  <= pwdata[31:0];
                REG_METADATA_TYPE: cfg_reg.metadata_type_code <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_MAGIC:         prdata = cfg_reg.magic_value;
            REG_VERSION:       prdata = {32'd0, cfg_reg.expected_version};
            REG_IR_TYPE:       prdata = {32'd0, cfg_reg.ir_type_code};
            REG_WEIGHTS_TYPE:  prdata = {32'd0, cfg_reg.weights_type_code};
            REG_METADATA_TYPE: prdata = {32'd0, cfg_reg.metadata_type_code};
            default:           prdata = '0;
        endcase
    end

endmodule

/* rtl/core/tlvchp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV container header parser: byte parser
// Per-byte parse state update and status evaluation on the final byte.
// ----------------------------------------------------------------------------
module tlvchp_parser
    import tlvchp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SECHDR = 3'd1;
    localparam logic [2:0] PH_BODY   = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    localparam logic [POS_BITS-1:0] POS_MAGIC_END   = POS_BITS'(MAGIC_BYTES);
    localparam logic [POS_BITS-1:0] POS_VERSION_END = POS_BITS'(MAGIC_BYTES + WORD_BYTES - 1);
    localparam logic [POS_BITS-1:0] POS_FLAGS_END   = POS_BITS'(MAGIC_BYTES + 2*WORD_BYTES - 1);
    localparam logic [POS_BITS-1:0] POS_HEADER_END  = POS_BITS'(HEADER_BYTES - 1);
    localparam logic [POS_BITS-1:0] POS_HEADER_LEN  = POS_BITS'(HEADER_BYTES);
    localparam logic [3:0]          HC_TYPE_DONE    = 4'(WORD_BYTES);
    localparam logic [3:0]          HC_LEN_DONE     = 4'(2 * WORD_BYTES);

    logic [2:0]             phase_reg, phase_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [31:0]            shift_reg, shift_next;
    logic [31:0]            left_reg, left_next;
    logic [31:0]            type_reg, type_next;
    logic [31:0]            body_reg, body_next;
    logic [31:0]            version_reg, version_next;
    logic [31:0]            flags_reg, flags_next;
    logic [OFFSET_BITS-1:0] rec_reg  [0:5];
    logic [OFFSET_BITS-1:0] rec_next [0:5];
    logic                   ir_seen_reg, ir_seen_next;
    logic [2:0]             error_reg, error_next;
    logic [3:0]             hc_reg, hc_next;

    logic                   take;
    logic [3:0]             hc_inc;
    logic [31:0]            left_dec;
    logic [31:0]            body_dec;
    logic [7:0]             magic_byte;
    logic [2:0]             status;

    // A finished section leads to the next header, or to the end of parsing.
    function automatic logic [2:0] after_section(input logic [31:0] left);
        logic [2:0] ph;
        ph = (left == 32'd0) ? PH_DONE : PH_SECHDR;
        return ph;
    endfunction

    // Only the first error is kept.
    function automatic logic [2:0] keep_error(input logic [2:0] held, input logic [2:0] code);
        logic [2:0] e;
        e = (held == ST_OK) ? code : held;
        return e;
    endfunction

    assign hc_inc     = hc_reg + 4'd1;
    assign left_dec   = left_reg - 32'd1;
    assign body_dec   = body_reg - 32'd1;
    assign magic_byte = cfg.magic_value[{pos_reg[2:0], 3'b000} +: 8];

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        type_next    = type_reg;
        body_next    = body_reg;
        version_next = version_reg;
        flags_next   = flags_reg;
        rec_next     = rec_reg;
        ir_seen_next = ir_seen_reg;
        error_next   = error_reg;
        hc_next      = hc_reg;
        take         = 1'b0;
        status       = ST_OK;
        res_valid    = 1'b0;
        res          = '0;

        if (in_fire) begin
            // The position saturates at the offset range; the byte at the last
            // representable offset and any bytes after it are not parsed.
            if (!pos_reg[OFFSET_BITS]) begin
                pos_next = pos_reg + POS_BITS'(1);
                take     = (pos_reg[OFFSET_BITS-1:0] != '1);
            end

            if (take) begin
                shift_next = {in_byte, shift_reg[31:8]};
                case (phase_reg)
                    PH_HEADER: begin
                        if (pos_reg < POS_MAGIC_END) begin
                            if (in_byte != magic_byte) begin
                                error_next = keep_error(error_reg, ST_BAD_MAGIC);
                                phase_next = PH_ERROR;
                            end
                        end else if (pos_reg == POS_VERSION_END) begin
                            version_next = shift_next;
                            if (shift_next != cfg.expected_version) begin
                                error_next = keep_error(error_reg, ST_BAD_VERSION);
                                phase_next = PH_ERROR;
                            end
                        end else if (pos_reg == POS_FLAGS_END) begin
                            flags_next = shift_next;
                        end else if (pos_reg == POS_HEADER_END) begin
                            left_next  = shift_next;
                            phase_next = after_section(shift_next);
                            hc_next    = 4'd0;
                        end
                    end
                    PH_SECHDR: begin
                        hc_next = hc_inc;
                        if (hc_inc == HC_TYPE_DONE) begin
                            type_next = shift_next;
                        end else if (hc_inc == HC_LEN_DONE) begin
                            // Equal type codes resolve to IR, then weights,
                            // then metadata.
                            if (type_reg == cfg.ir_type_code) begin
                                rec_next[0]  = pos_next[OFFSET_BITS-1:0];
                                rec_next[1]  = shift_next[OFFSET_BITS-1:0];
                                ir_seen_next = 1'b1;
                            end else if (type_reg == cfg.weights_type_code) begin
                                rec_next[2] = pos_next[OFFSET_BITS-1:0];
                                rec_next[3] = shift_next[OFFSET_BITS-1:0];
                            end else if (type_reg == cfg.metadata_type_code) begin
                                rec_next[4] = pos_next[OFFSET_BITS-1:0];
                                rec_next[5] = shift_next[OFFSET_BITS-1:0];
                            end
                            left_next = left_dec;
                            body_next = shift_next;
                            if (shift_next == 32'd0) begin
                                phase_next = after_section(left_dec);
                                hc_next    = 4'd0;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        body_next = body_dec;
                        if (body_dec == 32'd0) begin
                            phase_next = after_section(left_reg);
                            hc_next    = 4'd0;
                        end
                    end
                    default: ;
                endcase
            end

            if (in_last) begin
                if (pos_next[OFFSET_BITS]) begin
                    status = ST_TOO_LONG;
                end else if (pos_next < POS_HEADER_LEN) begin
                    status = ST_SHORT;
                end else if (error_next != ST_OK) begin
                    status = error_next;
                end else if (phase_next == PH_SECHDR) begin
                    status = ST_TRUNC_HDR;
                end else if (phase_next == PH_BODY) begin
                    status = ST_TRUNC_BODY;
                end else if (!ir_seen_next) begin
                    status = ST_NO_IR;
                end

                res_valid  = 1'b1;
                res.status = status;
                if (status != ST_SHORT && status != ST_BAD_MAGIC && status != ST_TOO_LONG) begin
                    res.version_word = version_next;
                    res.flags_word   = flags_next;
                end
                if (status == ST_OK) begin
                    res.ir_offset       = rec_next[0];
                    res.ir_length       = rec_next[1];
                    res.weights_offset  = rec_next[2];
                    res.weights_length  = rec_next[3];
                    res.metadata_offset = rec_next[4];
                    res.metadata_length = rec_next[5];
                end

                // The packet is closed: start the next one from a clean state.
                phase_next   = PH_HEADER;
                pos_next     = '0;
                left_next    = '0;
                type_next    = '0;
                body_next    = '0;
                version_next = '0;
                flags_next   = '0;
                for (int i = 0; i < 6; i++) begin
                    rec_next[i] = '0;
                end
                ir_seen_next = 1'b0;
                error_next   = ST_OK;
                hc_next      = 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            left_reg    <= '0;
            type_reg    <= '0;
            body_reg    <= '0;
            version_reg <= '0;
            flags_reg   <= '0;
            for (int i = 0; i < 6; i++) begin
                rec_reg[i] <= '0;
            end
            ir_seen_reg <= 1'b0;
            error_reg   <= ST_OK;
            hc_reg      <= 4'd0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            left_reg    <= left_next;
            type_reg    <= type_next;
            body_reg    <= body_next;
            version_reg <= version_next;
            flags_reg   <= flags_next;
            rec_reg     <= rec_next;
            ir_seen_reg <= ir_seen_next;
            error_reg   <= error_next;
            hc_reg      <= hc_next;
        end
    end

    // The shift register only ever supplies words after four fresh bytes.
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

endmodule

/* rtl/core/tlvchp_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV container header parser: result register
// Holds one finished result on the master side until it is taken.
// ----------------------------------------------------------------------------
module tlvchp_out_reg
    import tlvchp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;

    // A new byte may enter when no result is held, or when the held result leaves in the same cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            data_reg <= res;
        end
    end

endmodule

/* rtl/core/tlv_container_header_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV container header parser
// Streams a container packet one byte per transfer and reports its header and
// the placement of its IR, weights and metadata sections.
// ----------------------------------------------------------------------------
// Bytes arrive on the s_ channel, one per transfer, with s_tlast on the final
// byte of the packet. Each byte is parsed in the cycle it is taken; the whole
// parse step sits between the parse state registers and the result register.
// One result per packet leaves on the m_ channel, valid in the cycle after
// the transfer of the final byte. s_tready is low whenever a result is held
// and m_tready is low, so no byte is taken while the receiver stalls with a
// result waiting; when the held result leaves, a byte can be taken in the
// same cycle, and with m_tready high bytes stream in back to back.
// The APB port sets the magic value, accepted version and section type codes;
// the user must write it only while no packet is in flight (the block does not check).
// Reset (aresetn low, synchronous) clears the parse state and the result valid
// flag and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module tlv_container_header_parser_core
    import tlvchp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // in_byte
    input  logic                     s_tlast,   // in_last
    // Result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status, version_word, flags_word, ir_offset, ir_length, weights_offset,
    // weights_length, metadata_offset, metadata_length, then zero padding
    output logic [TDATA_BITS-1:0]    m_tdata,
    // Configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t    cfg;
    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign in_fire = s_tvalid && s_tready;
    assign m_tdata = TDATA_BITS'(out_data);

    tlvchp_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlvchp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    tlvchp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

endmodule

/* bench/tlv_container_header_parser_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV container header parser: result checker
// Watches the byte stream, the result stream and the configuration port,
// keeps its own copy of the parse state and registers, predicts the report
// for every packet and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module tlv_container_header_parser_checker
    import tlvchp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [7:0]               s_tdata,
    input  logic                     s_tlast,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [TDATA_BITS-1:0]    m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    output int                       fail_count,
    output int                       reports_pending,
    output int                       reports_checked
);

    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_SECTION_HDR,
        SCAN_BODY,
        SCAN_DONE,
        SCAN_HALTED
    } scan_phase_e;

    localparam logic [POS_BITS-1:0] POS_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

    cfg_t                   cfg;
    scan_phase_e            phase;
    logic [POS_BITS-1:0]    pos;
    logic [63:0]            shift;
    logic [31:0]            sections_due;
    logic [31:0]            sec_type;
    logic [31:0]            body_left;
    logic [31:0]            hdr_version;
    logic [31:0]            hdr_flags;
    logic [OFFSET_BITS-1:0] ir_off, ir_len, wt_off, wt_len, md_off, md_len;
    logic                   ir_found;
    logic [2:0]             first_error;
    int                     hdr_count;
    result_t                expected_reports[$];

    function automatic void restart_scan();
        phase        = SCAN_HEADER;
        pos          = '0;
        shift        = '0;
        sections_due = '0;
        sec_type     = '0;
        body_left    = '0;
        hdr_version  = '0;
        hdr_flags    = '0;
        ir_off       = '0;
        ir_len       = '0;
        wt_off       = '0;
        wt_len       = '0;
        md_off       = '0;
        md_len       = '0;
        ir_found     = 1'b0;
        first_error  = ST_OK;
        hdr_count    = 0;
    endfunction

    // Only the first error counts; the rest of the packet is skipped.
    function automatic void halt_with(logic [2:0] code);
        if (first_error == ST_OK) begin
            first_error = code;
        end
        phase = SCAN_HALTED;
    endfunction

    function automatic void end_of_section();
        if (sections_due == 0) begin
            phase = SCAN_DONE;
        end else begin
            phase     = SCAN_SECTION_HDR;
            hdr_count = 0;
        end
    endfunction

    function automatic void parse_byte(logic [POS_BITS-1:0] p, logic [7:0] value);
        logic [31:0]            len;
        logic [OFFSET_BITS-1:0] off;
        int                     idx;
        idx   = int'(p);
        shift = {value, shift[63:8]};
        case (phase)
            SCAN_HEADER: begin
                if (idx < MAGIC_BYTES) begin
                    if (value != cfg.magic_value[8*idx +: 8]) begin
                        halt_with(ST_BAD_MAGIC);
                    end
                end else if (idx == MAGIC_BYTES + WORD_BYTES - 1) begin
                    hdr_version = shift[63:32];
                    if (hdr_version != cfg.expected_version) begin
                        halt_with(ST_BAD_VERSION);
                    end
                end else if (idx == MAGIC_BYTES + 2 * WORD_BYTES - 1) begin
                    hdr_flags = shift[63:32];
                end else if (idx == HEADER_BYTES - 1) begin
                    sections_due = shift[63:32];
                    end_of_section();
                end
            end
            SCAN_SECTION_HDR: begin
                hdr_count++;
                if (hdr_count == WORD_BYTES) begin
                    sec_type = shift[63:32];
                end else if (hdr_count == 2 * WORD_BYTES) begin
                    len = shift[63:32];
                    off = p[OFFSET_BITS-1:0] + 1'b1;
                    // A type matching several registers goes to IR first,
                    // then weights, then metadata.
                    if (sec_type == cfg.ir_type_code) begin
                        ir_off   = off;
                        ir_len   = len[OFFSET_BITS-1:0];
                        ir_found = 1'b1;
                    end else if (sec_type == cfg.weights_type_code) begin
                        wt_off = off;
                        wt_len = len[OFFSET_BITS-1:0];
                    end else if (sec_type == cfg.metadata_type_code) begin
                        md_off = off;
                        md_len = len[OFFSET_BITS-1:0];
                    end
                    sections_due = sections_due - 1;
                    body_left    = len;
                    if (len == 0) begin
                        end_of_section();
                    end else begin
                        phase = SCAN_BODY;
                    end
                end
            end
            SCAN_BODY: begin
                body_left = body_left - 1;
                if (body_left == 0) begin
                    end_of_section();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void take_transfer(logic [7:0] value, logic last);
        result_t want;
        if (pos < POS_LIMIT) begin
            pos = pos + 1'b1;
            if (pos < POS_LIMIT) begin
                parse_byte(pos - 1'b1, value);
            end
        end
        if (last) begin
            want = '0;
            if (pos >= POS_LIMIT) begin
                want.status = ST_TOO_LONG;
            end else if (pos < HEADER_BYTES) begin
                want.status = ST_SHORT;
            end else if (first_error != ST_OK) begin
                want.status = first_error;
            end else if (phase == SCAN_SECTION_HDR) begin
                want.status = ST_TRUNC_HDR;
            end else if (phase == SCAN_BODY) begin
                want.status = ST_TRUNC_BODY;
            end else if (!ir_found) begin
                want.status = ST_NO_IR;
            end else begin
                want.status = ST_OK;
            end
            if (!(want.status inside {ST_SHORT, ST_BAD_MAGIC, ST_TOO_LONG})) begin
                want.version_word = hdr_version;
                want.flags_word   = hdr_flags;
            end
            if (want.status == ST_OK) begin
                want.ir_offset       = ir_off;
                want.ir_length       = ir_len;
                want.weights_offset  = wt_off;
                want.weights_length  = wt_len;
                want.metadata_offset = md_off;
                want.metadata_length = md_len;
            end
            expected_reports.push_back(want);
            restart_scan();
        end
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            note_failure($sformatf("result %0d, %s: expected 0x%0h, got 0x%0h",
                                   reports_checked, name, want, got));
        end
    endfunction

    function automatic void compare_report(result_t got);
        result_t want;
        if (expected_reports.size() == 0) begin
            note_failure("result transfer with no packet outstanding");
        end else begin
            want = expected_reports.pop_front();
            check_field("status", want.status, got.status);
            check_field("version_word", want.version_word, got.version_word);
            check_field("flags_word", want.flags_word, got.flags_word);
            check_field("ir_offset", want.ir_offset, got.ir_offset);
            check_field("ir_length", want.ir_length, got.ir_length);
            check_field("weights_offset", want.weights_offset, got.weights_offset);
            check_field("weights_length", want.weights_length, got.weights_length);
            check_field("metadata_offset", want.metadata_offset, got.metadata_offset);
            check_field("metadata_length", want.metadata_length, got.metadata_length);
            reports_checked++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.magic_value        = 64'd0;
            cfg.expected_version   = 32'd1;
            cfg.ir_type_code       = 32'd1;
            cfg.weights_type_code  = 32'd2;
            cfg.metadata_type_code = 32'd3;
            restart_scan();
            expected_reports.delete();
            fail_count      = 0;
            reports_checked = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_BITS-1:3])
                    REG_MAGIC:         cfg.magic_value        = pwdata;
                    REG_VERSION:       cfg.expected_version   = pwdata[31:0];
                    REG_IR_TYPE:       cfg.ir_type_code       = pwdata[31:0];
                    REG_WEIGHTS_TYPE:  cfg.weights_type_code  = pwdata[31:0];
                    REG_METADATA_TYPE: cfg.metadata_type_code = pwdata[31:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                take_transfer(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                compare_report(result_t'(m_tdata[RESULT_BITS-1:0]));
            end
        end
        reports_pending = expected_reports.size();
    end

endmodule

/* bench/tb_tlv_container_header_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV container header parser: testbench top
// Streams directed and random container packets through the parser under
// several register settings, with random gaps on both streams and one long
// stall of the result stream; the checker beside the block predicts and
// compares every report, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_tlv_container_header_parser_core;
    import tlvchp_pkg::*;

    localparam int ITEM_TARGET    = 1050;
    localparam int CLOSING_BYTES  = 150;
    localparam int MIN_STEPS      = 4;
    localparam int PHASE_PACKETS  = 3;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [TDATA_BITS-1:0]    m_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    int   fail_count;
    int   reports_pending;
    int   reports_checked;

    cfg_t       regs;
    logic [7:0] packet[$];
    int         bytes_sent;
    int         packets_sent;
    int         settings_used;
    bit         tx_gaps;
    bit         rx_gaps;
    bit         hold_request;

    tlv_container_header_parser_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tlv_container_header_parser_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .reports_pending (reports_pending),
        .reports_checked (reports_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls, and on request one long hold-off so that the
    // block fills up and has to stall its input.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Entered and left at a falling edge.
    task automatic send_byte(logic [7:0] value, logic last);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_packet(int count);
        for (int i = 0; i < count; i++) begin
            send_byte(packet[i], i == count - 1);
        end
        packet.delete();
        packets_sent++;
    endtask

    function automatic void push_word(logic [31:0] w);
        for (int i = 0; i < WORD_BYTES; i++) begin
            packet.push_back(w[8*i +: 8]);
        end
    endfunction

    function automatic void push_header(logic [31:0] version, logic [31:0] flags,
                                        logic [31:0] count);
        for (int i = 0; i < MAGIC_BYTES; i++) begin
            packet.push_back(regs.magic_value[8*i +: 8]);
        end
        push_word(version);
        push_word(flags);
        push_word(count);
    endfunction

    function automatic void push_section(logic [31:0] kind, logic [31:0] length,
                                         int body_bytes);
        push_word(kind);
        push_word(length);
        repeat (body_bytes) packet.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Waits until every report has arrived and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (reports_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        case (index)
            REG_MAGIC:         regs.magic_value        = value;
            REG_VERSION:       regs.expected_version   = value[31:0];
            REG_IR_TYPE:       regs.ir_type_code       = value[31:0];
            REG_WEIGHTS_TYPE:  regs.weights_type_code  = value[31:0];
            REG_METADATA_TYPE: regs.metadata_type_code = value[31:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(int step);
        logic [31:0] codes[3];
        case (step)
            0: begin
                write_reg(REG_MAGIC, 64'hffff_ffff_ffff_ffff);
                write_reg(REG_VERSION, 64'h0000_0000_ffff_ffff);
                codes = '{32'hffff_ffff, 32'hffff_fffe, 32'h0};
            end
            1: begin
                // All type codes equal: every known section counts as IR.
                write_reg(REG_MAGIC, 64'h0);
                write_reg(REG_VERSION, 64'h0);
                codes = '{32'h0, 32'h0, 32'h0};
            end
            2: begin
                write_reg(REG_MAGIC, {$urandom(), $urandom()});
                write_reg(REG_VERSION, 64'($urandom_range(0, 3)));
                codes = '{32'd5, 32'd7, 32'd7};
            end
            default: begin
                write_reg(REG_MAGIC, {$urandom(), $urandom()});
                write_reg(REG_VERSION, 64'($urandom()));
                for (int i = 0; i < 3; i++) begin
                    codes[i] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) : $urandom();
                end
            end
        endcase
        write_reg(REG_IR_TYPE, 64'(codes[0]));
        write_reg(REG_WEIGHTS_TYPE, 64'(codes[1]));
        write_reg(REG_METADATA_TYPE, 64'(codes[2]));
        settings_used++;
    endtask

    // Mostly well-formed packets with random content; the rest are cut short,
    // carry a bad magic, version or section count, or are plain noise.
    task automatic send_random_packet();
        int          mode;
        int          sections;
        int          length;
        int          count;
        logic [31:0] kind;
        logic [31:0] word;
        mode = $urandom_range(0, 99);
        if (mode >= 94) begin
            repeat ($urandom_range(1, 40)) packet.push_back(8'($urandom_range(0, 255)));
            send_packet(packet.size());
        end else begin
            sections = $urandom_range(0, 4);
            push_header(regs.expected_version, $urandom(), sections);
            for (int i = 0; i < sections; i++) begin
                case ($urandom_range(0, 4))
                    0, 1: kind = regs.ir_type_code;
                    2:    kind = regs.weights_type_code;
                    3:    kind = regs.metadata_type_code;
                    default: kind = $urandom();
                endcase
                if ($urandom_range(0, 19) == 0) begin
                    // Oversized length word with only a few body bytes behind it.
                    push_section(kind, $urandom(), $urandom_range(0, 5));
                end else begin
                    length = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                         : $urandom_range(0, 6);
                    push_section(kind, length, length);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) packet.push_back(8'($urandom_range(0, 255)));
            end
            count = packet.size();
            if (mode >= 89) begin
                word = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff
                                                   : sections + $urandom_range(1, 3);
                for (int i = 0; i < WORD_BYTES; i++) begin
                    packet[HEADER_BYTES - WORD_BYTES + i] = word[8*i +: 8];
                end
            end else if (mode >= 84) begin
                packet[MAGIC_BYTES + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            end else if (mode >= 78) begin
                packet[$urandom_range(0, MAGIC_BYTES - 1)] ^= 8'(1 << $urandom_range(0, 7));
            end else if (mode >= 70) begin
                count = $urandom_range(1, packet.size());
            end
            send_packet(count);
        end
    endtask

    initial begin
        int step;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_request  = 1'b0;
        bytes_sent    = 0;
        packets_sent  = 0;
        settings_used = 1;
        regs.magic_value        = 64'd0;
        regs.expected_version   = 32'd1;
        regs.ir_type_code       = 32'd1;
        regs.weights_type_code  = 32'd2;
        regs.metadata_type_code = 32'd3;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed packets under the reset settings.
        packet.push_back(8'hff);
        send_packet(1);
        push_header(regs.expected_version, 32'h0, 32'd0);
        send_packet(HEADER_BYTES - 1);
        push_header(regs.expected_version, 32'hffff_ffff, 32'd0);
        send_packet(packet.size());
        push_header(regs.expected_version, 32'h0, 32'd1);
        packet[MAGIC_BYTES - 1] ^= 8'h80;
        push_section(regs.ir_type_code, 32'd4, 4);
        send_packet(packet.size());
        push_header(~regs.expected_version, 32'h1234_5678, 32'd1);
        push_section(regs.ir_type_code, 32'd4, 4);
        send_packet(packet.size());
        // Ended inside a section header, then at one with sections still due.
        push_header(regs.expected_version, 32'h0, 32'd1);
        push_section(regs.ir_type_code, 32'd4, 4);
        send_packet(HEADER_BYTES + 5);
        push_header(regs.expected_version, 32'h0, 32'd2);
        push_section(regs.ir_type_code, 32'd2, 2);
        send_packet(packet.size());
        // Ended inside a section body, once with the largest length word.
        push_header(regs.expected_version, 32'h0, 32'd1);
        push_section(regs.ir_type_code, 32'd4, 2);
        send_packet(packet.size());
        push_header(regs.expected_version, 32'h0, 32'd1);
        push_section(regs.ir_type_code, 32'hffff_ffff, 3);
        send_packet(packet.size());
        // Every section kind, a zero-length one, an unknown type, a repeated
        // IR section and trailing bytes after the last section.
        push_header(regs.expected_version, 32'h5a5a_a5a5, 32'd5);
        push_section(regs.ir_type_code, 32'd3, 3);
        push_section(regs.weights_type_code, 32'd0, 0);
        push_section(32'hdead_beef, 32'd2, 2);
        push_section(regs.metadata_type_code, 32'd1, 1);
        push_section(regs.ir_type_code, 32'd2, 2);
        packet.push_back(8'h00);
        packet.push_back(8'hff);
        send_packet(packet.size());

        step = 0;
        while (bytes_sent < ITEM_TARGET - CLOSING_BYTES || step < MIN_STEPS) begin
            settle();
            apply_settings(step);
            rx_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_PACKETS; i++) begin
                if (step == 3 && i == 1) begin
                    hold_request = 1'b1;
                end
                tx_gaps = ($urandom_range(0, 3) != 0);
                send_random_packet();
            end
            step++;
        end

        // Closing stretch with both streams running flat out.
        settle();
        apply_settings(step);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (PHASE_PACKETS) send_random_packet();
        settle();

        $display("Streamed %0d bytes in %0d packets under %0d register settings.",
                 bytes_sent, packets_sent, settings_used);
        $display("Compared %0d reports; %0d failures recorded.", reports_checked, fail_count);
        if (fail_count == 0 && reports_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
